// ===== src/dtlv_pkg.sv =====
package dtlv_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CLASS_W    = 2;
    localparam int unsigned TAG_W      = 32;
    localparam int unsigned LENGTH_W   = 31;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned LEFT_W     = 7;

    // Tag field value that announces a high tag number.
    localparam logic [4:0] TAG_ESCAPE = 5'h1F;
    // Saturation value of the identifier byte count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDENT    = 2'd0,
        PH_HIGHTAG  = 2'd1,
        PH_LENFIRST = 2'd2,
        PH_LENMORE  = 2'd3
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEF = 2'd1,
        ST_BIG   = 2'd2
    } t_status;

endpackage

// ===== src/dtlv_if.sv =====
interface dtlv_in_if;
    import dtlv_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface dtlv_out_if;
    import dtlv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  tag_class;
    logic                constructed;
    logic [TAG_W-1:0]    tag_number;
    logic [LENGTH_W-1:0] content_length;
    logic [COUNT_W-1:0]  identifier_bytes;
    logic [COUNT_W-1:0]  length_bytes;

    modport source (
        output valid, output status, output tag_class, output constructed,
        output tag_number, output content_length, output identifier_bytes,
        output length_bytes, input ready
    );
    modport sink (
        input valid, input status, input tag_class, input constructed,
        input tag_number, input content_length, input identifier_bytes,
        input length_bytes, output ready
    );
endinterface

// ===== src/der_tlv_header_decoder_core.sv =====
// DER identifier-and-length header decoder.
// The input channel i_in carries one header byte per word, with a flag that
// marks the last byte of the stream. The output channel o_out carries one
// word per complete header: status, class, constructed flag, tag number,
// content length and the byte counts of the identifier and length fields.
// Bytes that do not complete a header produce no output word.
// Each accepted byte is first held in an input register. The parse step then
// updates the parser state from it, and the result register is loaded when a
// header completes; the step waits while the result register holds a word
// that the receiver does not take. A result shows on o_out straight from the
// result register. One byte is accepted per cycle while the receiver keeps
// up, since the parse step empties the input register as it is refilled.
// When the receiver stalls, a finished result waits in the result register
// while the next byte is still taken into the input register; only when that
// byte is waiting and the result register is still occupied does i_in.ready
// drop. A synchronous active-low reset empties both registers and returns
// the parser to expecting an identifier octet.
module der_tlv_header_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtlv_in_if.sink     i_in,
    dtlv_out_if.source  o_out
);
    import dtlv_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [DATA_W-1:0] r_byte;
    logic              r_eos;

    // Parser state.
    t_phase              r_phase,       n_phase;
    logic [CLASS_W-1:0]  r_class,       n_class;
    logic                r_constructed, n_constructed;
    logic [TAG_W-1:0]    r_tag,         n_tag;
    logic [COUNT_W-1:0]  r_id_count,    n_id_count;
    logic [LENGTH_W-1:0] r_len_accum,   n_len_accum;
    logic [LEFT_W-1:0]   r_len_left,    n_len_left;
    logic [COUNT_W-1:0]  r_len_count,   n_len_count;

    // Result register.
    logic                r_out_valid;
    t_status             r_status;
    logic [CLASS_W-1:0]  r_out_class;
    logic                r_out_constructed;
    logic [TAG_W-1:0]    r_out_tag;
    logic [LENGTH_W-1:0] r_out_length;
    logic [COUNT_W-1:0]  r_out_id_count;
    logic [COUNT_W-1:0]  r_out_len_count;

    logic                emit;
    t_status             emit_status;
    logic [LENGTH_W-1:0] emit_length;
    logic [LENGTH_W-1:0] shifted_accum;
    logic                out_free;
    logic                advance;

    // The parse step may run when the result register can take a new word.
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    assign shifted_accum = {r_len_accum[LENGTH_W-DATA_W-1:0], r_byte};

    always_comb begin
        n_phase       = r_phase;
        n_class       = r_class;
        n_constructed = r_constructed;
        n_tag         = r_tag;
        n_id_count    = r_id_count;
        n_len_accum   = r_len_accum;
        n_len_left    = r_len_left;
        n_len_count   = r_len_count;
        emit          = 1'b0;
        emit_status   = ST_OK;
        emit_length   = '0;

        unique case (r_phase)
            PH_IDENT: begin
                n_class       = r_byte[7:6];
                n_constructed = r_byte[5];
                n_id_count    = COUNT_W'(1);
                if (r_byte[4:0] == TAG_ESCAPE) begin
                    n_tag   = '0;
                    n_phase = PH_HIGHTAG;
                end else begin
                    n_tag   = TAG_W'(r_byte[4:0]);
                    n_phase = PH_LENFIRST;
                end
            end
            PH_HIGHTAG: begin
                // Seven bits per byte, wrapping at the tag width.
                n_tag = {r_tag[TAG_W-8:0], r_byte[6:0]};
                if (r_id_count != COUNT_MAX) begin
                    n_id_count = r_id_count + COUNT_W'(1);
                end
                if (r_eos || !r_byte[7]) begin
                    n_phase = PH_LENFIRST;
                end
            end
            PH_LENFIRST: begin
                n_len_count = COUNT_W'(1);
                if (!r_byte[7]) begin
                    emit        = 1'b1;
                    emit_length = LENGTH_W'(r_byte);
                end else if (r_byte[6:0] == '0) begin
                    emit        = 1'b1;
                    emit_status = ST_INDEF;
                    n_len_left  = '0;
                end else begin
                    n_len_left  = r_byte[6:0];
                    n_len_count = COUNT_W'(r_byte[6:0]) + COUNT_W'(1);
                    n_len_accum = '0;
                    n_phase     = PH_LENMORE;
                end
            end
            PH_LENMORE: begin
                // Another byte would overflow once the value reaches 2^23.
                if (r_len_accum[LENGTH_W-1:LENGTH_W-DATA_W] != '0) begin
                    emit        = 1'b1;
                    emit_status = ST_BIG;
                end else begin
                    n_len_accum = shifted_accum;
                    n_len_left  = r_len_left - LEFT_W'(1);
                    if (r_len_left == LEFT_W'(1)) begin
                        emit        = 1'b1;
                        emit_length = shifted_accum;
                    end
                end
            end
            default: begin
                n_phase = PH_IDENT;
            end
        endcase

        if (emit) begin
            n_phase = PH_IDENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_eos  <= i_in.end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDENT;
            r_class       <= '0;
            r_constructed <= 1'b0;
            r_tag         <= '0;
            r_id_count    <= '0;
            r_len_accum   <= '0;
            r_len_left    <= '0;
            r_len_count   <= '0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_class       <= n_class;
            r_constructed <= n_constructed;
            r_tag         <= n_tag;
            r_id_count    <= n_id_count;
            r_len_accum   <= n_len_accum;
            r_len_left    <= n_len_left;
            r_len_count   <= n_len_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_status          <= emit_status;
            r_out_class       <= n_class;
            r_out_constructed <= n_constructed;
            r_out_tag         <= n_tag;
            r_out_length      <= emit_length;
            r_out_id_count    <= n_id_count;
            r_out_len_count   <= n_len_count;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_status;
    assign o_out.tag_class        = r_out_class;
    assign o_out.constructed      = r_out_constructed;
    assign o_out.tag_number       = r_out_tag;
    assign o_out.content_length   = r_out_length;
    assign o_out.identifier_bytes = r_out_id_count;
    assign o_out.length_bytes     = r_out_len_count;

endmodule

// ===== src/dtlv_checker.sv =====
module dtlv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [dtlv_pkg::STATUS_W-1:0]   i_status,
    input logic [dtlv_pkg::LENGTH_W-1:0]   i_content_length,
    input logic [dtlv_pkg::COUNT_W-1:0]    i_identifier_bytes,
    input logic [dtlv_pkg::COUNT_W-1:0]    i_length_bytes
);
    import dtlv_pkg::*;

    // A stalled result stays in place until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_content_length))
        else $error("result dropped or changed while stalled");

    // Error results carry no length, and an indefinite one uses one length byte.
    a_err_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_content_length == '0)
        else $error("error result with nonzero length");

    a_indef_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_INDEF |-> i_length_bytes == COUNT_W'(1))
        else $error("indefinite length result with wrong length byte count");

    // Every result has an identifier octet; a short form length stays below 128.
    a_short_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OK && i_length_bytes == COUNT_W'(1)
        |-> i_content_length < LENGTH_W'(128) && i_identifier_bytes != '0)
        else $error("short form result out of range");

endmodule

bind der_tlv_header_decoder_core dtlv_checker u_dtlv_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_status           (o_out.status),
    .i_content_length   (o_out.content_length),
    .i_identifier_bytes (o_out.identifier_bytes),
    .i_length_bytes     (o_out.length_bytes)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the DER identifier-and-length header decoder.
//
// A queue of header bytes is filled once at the start of the run: a short
// directed part that hits the corner cases of the identifier and length
// fields, then random headers. Most of them are well formed with random
// content. The rest are stray bytes and broken length fields. A clocked
// driver feeds the queue into the input channel at the falling edge. A
// clocked monitor samples both channels at the rising edge. Every byte the
// block accepts is also run through a local decoder, which queues the
// header word that the block should produce. Each word the block delivers
// is compared with the oldest queued one, field by field.
module tb_top;
    import dtlv_pkg::*;

    // Percentage of cycles in which either side idles.
    localparam int unsigned IDLE_PCT     = 38;
    // Bytes to queue beyond the directed part: the long tag, the long length, then random headers.
    localparam int unsigned RANDOM_BYTES = 1800;
    // Window, in accepted bytes, in which neither side idles.
    localparam int unsigned CALM_FROM    = 900;
    localparam int unsigned CALM_TO      = 1200;
    // The receiver stalls once, for a long time, after this many bytes.
    localparam int unsigned STALL_AT     = 400;
    localparam int unsigned STALL_CYCLES = 80;
    // A long form length at or above 2^23 cannot take one more byte.
    localparam logic [LENGTH_W-1:0] LEN_LIMIT = 31'h0080_0000;

    // One byte of the header stream, as offered on the input channel.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              eos;
    } t_stream_byte;

    // One output word of the block.
    typedef struct packed {
        t_status             status;
        logic [CLASS_W-1:0]  tag_class;
        logic                constructed;
        logic [TAG_W-1:0]    tag_number;
        logic [LENGTH_W-1:0] content_length;
        logic [COUNT_W-1:0]  identifier_bytes;
        logic [COUNT_W-1:0]  length_bytes;
    } t_header;

    logic i_clk;
    logic i_rst_n;

    dtlv_in_if  in_bus ();
    dtlv_out_if out_bus ();

    der_tlv_header_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_stream_byte stream_q[$];      // bytes still to be offered
    t_header      headers_due[$];   // header words the block still owes

    // State of the local decoder, which tracks the block byte by byte.
    t_phase              dec_phase;
    logic [CLASS_W-1:0]  dec_class;
    logic                dec_constructed;
    logic [TAG_W-1:0]    dec_tag;
    logic [COUNT_W-1:0]  dec_id_count;
    logic [LENGTH_W-1:0] dec_length;
    logic [LEFT_W-1:0]   dec_left;
    logic [COUNT_W-1:0]  dec_length_count;

    logic        in_fire = 1'b0;
    logic        draining = 1'b0;
    int unsigned bytes_in = 0;
    int unsigned headers_checked = 0;
    int unsigned ok_seen = 0;
    int unsigned indef_seen = 0;
    int unsigned big_seen = 0;
    int unsigned longest_id = 0;
    int unsigned failures = 0;
    int unsigned stall_left = 0;
    logic        stall_done = 1'b0;

    // Neither side idles while the accepted byte count is in the calm window.
    wire calm = (bytes_in >= CALM_FROM) && (bytes_in < CALM_TO);

    // ------------------------------------------------------------------
    // Local decoder
    // ------------------------------------------------------------------

    // Finishes a header: builds the word the block must emit and sends the
    // decoder back to expecting an identifier octet.
    function automatic t_header finish_header(t_status status,
                                              logic [LENGTH_W-1:0] length);
        t_header h;
        h.status           = status;
        h.tag_class        = dec_class;
        h.constructed      = dec_constructed;
        h.tag_number       = dec_tag;
        h.content_length   = length;
        h.identifier_bytes = dec_id_count;
        h.length_bytes     = dec_length_count;
        dec_phase          = PH_IDENT;
        return h;
    endfunction

    // Advances the decoder by one accepted byte. A completed or rejected
    // header is appended to the queue of words due from the block.
    task automatic decode_header_byte(input logic [DATA_W-1:0] b, input logic eos);
        case (dec_phase)
            PH_IDENT: begin
                // End of stream on the identifier octet never ends anything,
                // not even an escaped tag, which still needs a byte.
                dec_class       = b[7:6];
                dec_constructed = b[5];
                dec_id_count    = 8'd1;
                if (b[4:0] == TAG_ESCAPE) begin
                    dec_tag   = '0;
                    dec_phase = PH_HIGHTAG;
                end else begin
                    dec_tag   = {27'd0, b[4:0]};
                    dec_phase = PH_LENFIRST;
                end
            end
            PH_HIGHTAG: begin
                // Base-128 digits shift in from the right; the top bits
                // simply fall off once the tag exceeds 32 bits.
                dec_tag = {dec_tag[TAG_W-8:0], b[6:0]};
                if (dec_id_count != COUNT_MAX) begin
                    dec_id_count = dec_id_count + 8'd1;
                end
                if (eos || !b[7]) begin
                    dec_phase = PH_LENFIRST;
                end
            end
            PH_LENFIRST: begin
                dec_length_count = 8'd1;
                if (!b[7]) begin
                    headers_due.push_back(finish_header(ST_OK, {23'd0, b}));
                end else if (b[6:0] == '0) begin
                    headers_due.push_back(finish_header(ST_INDEF, '0));
                end else begin
                    dec_left         = b[6:0];
                    dec_length_count = 8'd1 + {1'b0, b[6:0]};
                    dec_length       = '0;
                    dec_phase        = PH_LENMORE;
                end
            end
            default: begin
                // Another byte would push the length past 31 bits. The
                // rejected byte is consumed; any declared bytes that remain
                // are parsed as the start of a new header.
                if (dec_length >= LEN_LIMIT) begin
                    headers_due.push_back(finish_header(ST_BIG, '0));
                end else begin
                    dec_length = {dec_length[LENGTH_W-9:0], b};
                    dec_left   = dec_left - 7'd1;
                    if (dec_left == '0) begin
                        headers_due.push_back(finish_header(ST_OK, dec_length));
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking helpers
    // ------------------------------------------------------------------

    // Only the first ten failures are printed; the rest are just counted.
    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic string header_text(t_header h);
        return $sformatf(
            "status=%0d class=%0d cons=%0b tag=%08h len=%08h idb=%0d lenb=%0d",
            h.status, h.tag_class, h.constructed, h.tag_number,
            h.content_length, h.identifier_bytes, h.length_bytes);
    endfunction

    // Names every field in which the two words differ.
    function automatic string header_diff(t_header want, t_header got);
        string s;
        s = "";
        if (want.status != got.status)                     s = {s, " status"};
        if (want.tag_class != got.tag_class)               s = {s, " tag_class"};
        if (want.constructed != got.constructed)           s = {s, " constructed"};
        if (want.tag_number != got.tag_number)             s = {s, " tag_number"};
        if (want.content_length != got.content_length)     s = {s, " content_length"};
        if (want.identifier_bytes != got.identifier_bytes) s = {s, " identifier_bytes"};
        if (want.length_bytes != got.length_bytes)         s = {s, " length_bytes"};
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [DATA_W-1:0] b, input logic eos);
        stream_q.push_back('{data: b, eos: eos});
    endtask

    // End of stream is marked now and then on bytes where it means nothing,
    // to show that the block ignores it there.
    function automatic logic stray_eos();
        return ($urandom_range(9) == 0);
    endfunction

    // Queues a length field. Most are well formed; some are long form
    // lengths whose first byte is already too large for 31 bits.
    task automatic push_random_length();
        int unsigned pick;
        int unsigned count;
        logic [DATA_W-1:0] b;
        pick = $urandom_range(99);
        if (pick < 40) begin
            push_byte(8'($urandom_range(127)), stray_eos());
        end else if (pick < 50) begin
            push_byte(8'h80, stray_eos());
        end else if (pick < 60) begin
            // Oversized: the fourth length byte is rejected.
            count = $urandom_range(8, 4);
            push_byte(8'h80 | 8'(count), stray_eos());
            for (int i = 0; i < count; i++) begin
                b = 8'($urandom_range(255));
                if (i == 0) b[7] = 1'b1;
                push_byte(b, stray_eos());
            end
        end else begin
            // Well formed: leading zeros, then at most four significant
            // bytes whose top byte keeps the value below 2^31.
            count = ($urandom_range(19) == 0) ? $urandom_range(127, 5)
                                              : $urandom_range(4, 1);
            push_byte(8'h80 | 8'(count), stray_eos());
            for (int i = 0; i < count; i++) begin
                if (i + 4 < count)       b = 8'h00;
                else if (i + 4 == count) b = 8'($urandom_range(127));
                else                     b = 8'($urandom_range(255));
                push_byte(b, stray_eos());
            end
        end
    endtask

    // Queues one random header, or a short burst of noise.
    task automatic push_random_header();
        logic [DATA_W-1:0] id;
        int unsigned digits;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(3, 1)) begin
                push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end else begin
            id = 8'($urandom_range(255));
            if ($urandom_range(2) == 0) id[4:0] = TAG_ESCAPE;
            push_byte(id, stray_eos());
            if (id[4:0] == TAG_ESCAPE) begin
                digits = $urandom_range(6, 1);
                for (int i = 1; i < digits; i++) begin
                    push_byte(8'h80 | 8'($urandom_range(127)), 1'b0);
                end
                // The tag ends on a clear top bit, or on end of stream.
                if ($urandom_range(4) == 0) begin
                    push_byte(8'h80 | 8'($urandom_range(127)), 1'b1);
                end else begin
                    push_byte(8'($urandom_range(127)), stray_eos());
                end
            end
            push_random_length();
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int unsigned directed_len;
        int unsigned waited;

        i_rst_n               = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = '0;
        in_bus.end_of_stream  = 1'b0;
        out_bus.ready         = 1'b0;

        dec_phase        = PH_IDENT;
        dec_class        = '0;
        dec_constructed  = 1'b0;
        dec_tag          = '0;
        dec_id_count     = '0;
        dec_length       = '0;
        dec_left         = '0;
        dec_length_count = '0;

        // Short tag, short length, with end of stream on the last byte.
        push_byte(8'h02, 1'b0); push_byte(8'h01, 1'b1);
        // Largest short tag in the private constructed class; largest short length.
        push_byte(8'hFE, 1'b0); push_byte(8'h7F, 1'b0);
        // Escaped tag with end of stream on the identifier octet itself,
        // two tag digits, then an indefinite length.
        push_byte(8'h1F, 1'b1); push_byte(8'h81, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        // High tag cut short by end of stream; largest legal length.
        push_byte(8'hDF, 1'b0); push_byte(8'hFF, 1'b1);
        push_byte(8'h84, 1'b0); push_byte(8'h7F, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        // Length too large: six declared bytes, rejected at the fourth; the
        // two that follow are read as a new header with zero length.
        push_byte(8'h24, 1'b0); push_byte(8'h86, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h05, 1'b0); push_byte(8'h00, 1'b0);
        // Leading zero in a long form length.
        push_byte(8'h30, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h10, 1'b0);
        directed_len = stream_q.size();

        // A very long high tag: the tag wraps at 32 bits and the identifier
        // byte count saturates.
        push_byte(8'h7F, 1'b0);
        repeat (259) push_byte(8'h80 | 8'($urandom_range(127)), 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        // The longest length field: 127 declared bytes, nearly all zero.
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b0);
        repeat (123) push_byte(8'h00, 1'b0);
        push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0); push_byte(8'h78, 1'b0);

        while (stream_q.size() < directed_len + RANDOM_BYTES) begin
            push_random_header();
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every byte has been taken by the block.
        while (stream_q.size() != 0 || in_bus.valid) begin
            @(posedge i_clk);
        end
        draining <= 1'b1;

        // Then until every header word has come out, within a bound.
        waited = 0;
        while (headers_due.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        // Wait on after that, so that a stray extra word would be seen.
        repeat (10) @(posedge i_clk);

        if (headers_due.size() != 0) begin
            note_failure($sformatf("%0d header words never arrived", headers_due.size()));
        end

        $display("Run covered %0d bytes and %0d header words: %0d ok, %0d indefinite, %0d too long.",
                 bytes_in, headers_checked, ok_seen, indef_seen, big_seen);
        $display("Longest identifier field was %0d bytes; %0d failures.", longest_id, failures);
        if (failures == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2ms;
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued bytes at the falling edge. A byte stays on the
    // channel until the block takes it; between words the sender idles at
    // random, except inside the calm window.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : feed_bytes
        t_stream_byte nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_fire) begin
            if (stream_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = stream_q.pop_front();
                in_bus.valid         <= 1'b1;
                in_bus.data_byte     <= nxt.data;
                in_bus.end_of_stream <= nxt.eos;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: takes header words at random, with one long stall part way
    // through. During the stall the sender keeps offering bytes, so both of
    // the block's registers fill and its input ready must drop.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (!stall_done && bytes_in >= STALL_AT) begin
            stall_done    <= 1'b1;
            stall_left    <= STALL_CYCLES;
            out_bus.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= draining || calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, an accepted byte goes through the local
    // decoder and an accepted header word is checked against the oldest one
    // due. The decoder runs first, though a word reaches the output only after
    // its last byte has passed through the input and result registers, so it
    // can never depend on a byte taken at the same edge.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : watch_channels
        t_header got;
        t_header want;
        string   diff;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_bus.valid && in_bus.ready;
            if (in_bus.valid && in_bus.ready) begin
                decode_header_byte(in_bus.data_byte, in_bus.end_of_stream);
                bytes_in++;
            end
            if (out_bus.valid && out_bus.ready) begin
                got.status           = t_status'(out_bus.status);
                got.tag_class        = out_bus.tag_class;
                got.constructed      = out_bus.constructed;
                got.tag_number       = out_bus.tag_number;
                got.content_length   = out_bus.content_length;
                got.identifier_bytes = out_bus.identifier_bytes;
                got.length_bytes     = out_bus.length_bytes;
                headers_checked++;
                case (got.status)
                    ST_OK:    ok_seen++;
                    ST_INDEF: indef_seen++;
                    ST_BIG:   big_seen++;
                    default:  ;
                endcase
                if (got.identifier_bytes > longest_id) longest_id = got.identifier_bytes;
                if (headers_due.size() == 0) begin
                    note_failure($sformatf("Unexpected header word: %s", header_text(got)));
                end else begin
                    want = headers_due.pop_front();
                    diff = header_diff(want, got);
                    if (diff != "") begin
                        note_failure($sformatf(
                            "Header word %0d differs in%s\n  expected %s\n  actual   %s",
                            headers_checked, diff, header_text(want), header_text(got)));
                    end
                end
            end
        end
    end

endmodule
